FILE: sv/sorted_record_table_macros.svh
// ----------------------------------------------------------------------------
// sorted_record_table_macros: assertion helpers
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_MACROS_SVH
`define SORTED_RECORD_TABLE_MACROS_SVH

// Same-cycle implication
`define SRT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_record_table: same-cycle check failed");

// Next-cycle implication
`define SRT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_record_table: next-cycle check failed");

`endif

FILE: sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared constants, codes and types of the sorted record table.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  localparam int ENTRIES    = 16;
  localparam int NAME_BYTES = 8;
  localparam int NAME_W     = NAME_BYTES * 8;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  localparam logic [63:0] NAME_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - NAME_W);

  // command modes
  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_SORT   = 3'd2;
  localparam logic [2:0] MODE_SEARCH = 3'd3;
  localparam logic [2:0] MODE_LIST   = 3'd4;

  // sort keys / order marks
  localparam logic [1:0] SF_NONE = 2'd0;
  localparam logic [1:0] SF_NAME = 2'd1;
  localparam logic [1:0] SF_QTY  = 2'd2;
  localparam logic [1:0] SF_PRI  = 2'd3;

  // result status
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_UNSORTED = 3'd5;
  localparam logic [2:0] ST_BADKEY   = 3'd6;

  typedef struct packed {
    logic [63:0] name;
    logic [15:0] qty;
    logic [7:0]  pri;
  } entry_t;

  // what a cell loads at the next edge
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_FROM_R = 3'd2,
    OP_FROM_L = 3'd3,
    OP_MERGE  = 3'd4
  } cell_op_t;

  // command data broadcast to every cell
  typedef struct packed {
    logic [63:0] key;
    logic [15:0] qty;
    logic [7:0]  pri;
    logic [1:0]  field;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/sorted_record_table.sv
// ----------------------------------------------------------------------------
// sorted_record_table
// Record table held in a row of entry cells, with insert/merge, remove,
// stable sort, binary search by name and list.
// ----------------------------------------------------------------------------
// Sequence: insert and remove give their result from the EXEC state; sort
//   runs ENTRIES odd-even exchange rounds across the cell row, one per
//   cycle; search makes one probe per cycle and gives its result on a hit
//   or once the range is empty; list gives one result per cycle, starting
//   after the EXEC state.
// Throughput: one command at a time; busy drops as the last result is strobed.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous): empty table, unsorted, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_record_table_macros.svh"

module sorted_record_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_mode,
  input  wire logic [63:0] in_name_key,
  input  wire logic [15:0] in_add_quantity,
  input  wire logic [7:0]  in_new_priority,
  input  wire logic [1:0]  in_sort_field,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [63:0]      out_entry_name,
  output logic [15:0]      out_entry_quantity,
  output logic [7:0]       out_entry_priority,
  output logic [3:0]       out_entry_position,
  output logic [2:0]       out_probe_count,
  output logic [4:0]       out_entry_count,
  output logic             out_last
);

  localparam int IW = srt_pkg::IDX_W;
  localparam int CW = srt_pkg::CNT_W;
  localparam int N  = srt_pkg::ENTRIES;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_SORT   = 5'b00100,
    ST_SEARCH = 5'b01000,
    ST_LIST   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // captured command
  logic [2:0]    mode_r;
  srt_pkg::cmd_t cmd_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    order_r, order_nxt;
  logic [IW-1:0] step_r, step_nxt;   // sort round or list index
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [2:0]    probes_r, probes_nxt;

  // cell row
  srt_pkg::entry_t   ent   [N];
  srt_pkg::entry_t   ent_l [N];
  srt_pkg::entry_t   ent_rt[N];
  srt_pkg::cell_op_t op    [N];
  logic [N-1:0]      match, gt;

  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == 0) begin : g_lend
      assign ent_l[g] = '0;
    end else begin : g_lmid
      assign ent_l[g] = ent[g-1];
    end
    if (g == N - 1) begin : g_rend
      assign ent_rt[g] = '0;
    end else begin : g_rmid
      assign ent_rt[g] = ent[g+1];
    end
    srt_cell u_cell (
      .clk     (clk),
      .op      (op[g]),
      .cmd     (cmd_r),
      .ent_l   (ent_l[g]),
      .ent_r   (ent_rt[g]),
      .ent_o   (ent[g]),
      .match_o (match[g]),
      .gt_o    (gt[g])
    );
  end

  // first valid name match
  logic          hit;
  logic [IW-1:0] hit_pos;
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i] && (CW'(i) < cnt_r)) begin
        hit     = 1'b1;
        hit_pos = IW'(i);
      end
    end
  end

  // binary search probe
  logic [CW:0]   mid_sum;
  logic [IW-1:0] mid;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - {{CW{1'b0}}, 1'b1};
  assign mid     = IW'(mid_sum >> 1);

  // result register contents
  logic            emit;
  logic [2:0]      e_status;
  logic            e_show;
  srt_pkg::entry_t e_ent;
  logic [IW-1:0]   e_pos;
  logic [2:0]      e_probes;
  logic            e_last;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    order_nxt  = order_r;
    step_nxt   = step_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    probes_nxt = probes_r;
    emit       = 1'b0;
    e_status   = srt_pkg::ST_DONE;
    e_show     = 1'b0;
    e_ent      = ent[mid];
    e_pos      = '0;
    e_probes   = '0;
    e_last     = 1'b1;
    for (int i = 0; i < N; i++) op[i] = srt_pkg::OP_HOLD;

    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (mode_r)
          srt_pkg::MODE_INSERT: begin
            emit = 1'b1;
            if (hit) begin
              op[hit_pos] = srt_pkg::OP_MERGE;
              e_pos       = hit_pos;
            end else if (cnt_r >= CW'(N)) begin
              e_status = srt_pkg::ST_FULL;
            end else begin
              op[IW'(cnt_r)] = srt_pkg::OP_LOAD;
              e_status       = srt_pkg::ST_ADDED;
              e_pos          = IW'(cnt_r);
              cnt_nxt        = cnt_r + 1'b1;
              order_nxt      = srt_pkg::SF_NONE;
            end
          end
          srt_pkg::MODE_REMOVE: begin
            emit = 1'b1;
            if (cnt_r == '0) begin
              e_status = srt_pkg::ST_EMPTY;
            end else if (!hit) begin
              e_status = srt_pkg::ST_NOTFOUND;
            end else begin
              // close the gap: the matching cell and every later filled cell take their right neighbor
              for (int i = 0; i < N; i++) begin
                if ((IW'(i) >= hit_pos) && (CW'(i + 1) < cnt_r)) op[i] = srt_pkg::OP_FROM_R;
              end
              e_pos     = hit_pos;
              cnt_nxt   = cnt_r - 1'b1;
              order_nxt = srt_pkg::SF_NONE;
            end
          end
          srt_pkg::MODE_SORT: begin
            if (cmd_r.field == srt_pkg::SF_NONE) begin
              emit     = 1'b1;
              e_status = srt_pkg::ST_BADKEY;
            end else begin
              step_nxt  = '0;
              state_nxt = ST_SORT;
            end
          end
          srt_pkg::MODE_SEARCH: begin
            if (order_r != srt_pkg::SF_NAME) begin
              emit     = 1'b1;
              e_status = srt_pkg::ST_UNSORTED;
            end else begin
              lo_nxt     = '0;
              hi_nxt     = cnt_r;
              probes_nxt = '0;
              state_nxt  = ST_SEARCH;
            end
          end
          srt_pkg::MODE_LIST: begin
            if (cnt_r == '0) begin
              emit     = 1'b1;
              e_status = srt_pkg::ST_EMPTY;
            end else begin
              step_nxt  = '0;
              state_nxt = ST_LIST;
            end
          end
          default: ;
        endcase
      end
      ST_SORT: begin
        // odd-even exchange round; swaps only strictly greater pairs (stable)
        for (int i = 0; i < N - 1; i++) begin
          if (((i % 2) == int'(step_r[0])) && (CW'(i + 1) < cnt_r) && gt[i]) begin
            op[i]   = srt_pkg::OP_FROM_R;
            op[i+1] = srt_pkg::OP_FROM_L;
          end
        end
        step_nxt = step_r + 1'b1;
        if (step_r == IW'(N - 1)) begin
          emit      = 1'b1;
          order_nxt = cmd_r.field;
          state_nxt = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (lo_r < hi_r) begin
          probes_nxt = probes_r + 1'b1;
          if (ent[mid].name == cmd_r.key) begin
            emit      = 1'b1;
            e_show    = 1'b1;
            e_pos     = mid;
            e_probes  = probes_r + 1'b1;
            state_nxt = ST_IDLE;
          end else if (ent[mid].name < cmd_r.key) begin
            lo_nxt = CW'(mid) + 1'b1;
          end else begin
            hi_nxt = CW'(mid);
          end
        end else begin
          emit      = 1'b1;
          e_status  = srt_pkg::ST_NOTFOUND;
          e_probes  = probes_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_LIST: begin
        emit     = 1'b1;
        e_show   = 1'b1;
        e_ent    = ent[step_r];
        e_pos    = step_r;
        e_last   = (CW'(step_r) + 1'b1 == cnt_r);
        step_nxt = step_r + 1'b1;
        if (e_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      order_r   <= srt_pkg::SF_NONE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      order_r   <= order_nxt;
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mode_r    <= in_mode;
      cmd_r.key <= in_name_key & srt_pkg::NAME_MASK;
      cmd_r.qty <= in_add_quantity;
      cmd_r.pri <= in_new_priority;
      cmd_r.field <= in_sort_field;
    end
    step_r   <= step_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    probes_r <= probes_nxt;
    if (emit) begin
      out_status         <= e_status;
      out_entry_name     <= e_show ? e_ent.name : '0;
      out_entry_quantity <= e_show ? e_ent.qty : '0;
      out_entry_priority <= e_show ? e_ent.pri : '0;
      out_entry_position <= 4'(e_pos);
      out_probe_count    <= e_probes;
      out_entry_count    <= 5'(cnt_nxt);
      out_last           <= e_last;
    end
  end

  `SRT_ASSERT_IMP(a_cnt_max, 1'b1, cnt_r <= CW'(N))
  `SRT_ASSERT_IMP(a_last_idle, out_valid && out_last, state_r == ST_IDLE)
  `SRT_ASSERT_IMP(a_more_list, out_valid && !out_last, state_r == ST_LIST)
  `SRT_ASSERT_NXT(a_no_early, start && !busy, !out_valid)

endmodule

`default_nettype wire

FILE: sv/srt_cell.sv
// ----------------------------------------------------------------------------
// srt_cell
// One table entry: load, match, neighbor compare, merge and neighbor transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_cell (
  input  wire logic              clk,
  input  wire srt_pkg::cell_op_t op,
  input  wire srt_pkg::cmd_t     cmd,
  input  wire srt_pkg::entry_t   ent_l,
  input  wire srt_pkg::entry_t   ent_r,
  output srt_pkg::entry_t        ent_o,
  output logic                   match_o,
  output logic                   gt_o
);

  srt_pkg::entry_t ent_r_reg;
  logic [16:0]     sum;

  assign sum     = {1'b0, ent_r_reg.qty} + {1'b0, cmd.qty};
  assign ent_o   = ent_r_reg;
  assign match_o = (ent_r_reg.name == cmd.key);

  // this entry's key greater than the right neighbor's
  always_comb begin
    case (cmd.field)
      srt_pkg::SF_NAME: gt_o = ent_r_reg.name > ent_r.name;
      srt_pkg::SF_QTY:  gt_o = ent_r_reg.qty > ent_r.qty;
      default:          gt_o = ent_r_reg.pri > ent_r.pri;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (op)
      srt_pkg::OP_LOAD: begin
        ent_r_reg.name <= cmd.key;
        ent_r_reg.qty  <= cmd.qty;
        ent_r_reg.pri  <= cmd.pri;
      end
      srt_pkg::OP_FROM_R: ent_r_reg <= ent_r;
      srt_pkg::OP_FROM_L: ent_r_reg <= ent_l;
      srt_pkg::OP_MERGE: begin
        ent_r_reg.qty <= sum[16] ? 16'hFFFF : sum[15:0];
        if (ent_r_reg.pri < cmd.pri) ent_r_reg.pri <= cmd.pri;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: test/tb_sorted_record_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_record_table
// Self-checking bench for the record table: a clocked driver feeds commands
// from a queue with bursty idle gaps. A local table model predicts every
// result at the transfer edge, and a clocked monitor compares each strobed
// result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_record_table;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_ITEMS   = 360;

  // a mode the table ignores
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]  mode;
    logic [63:0] key;
    logic [15:0] qty;
    logic [7:0]  pri;
    logic [1:0]  field;
  } command_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] name;
    logic [15:0] qty;
    logic [7:0]  pri;
    logic [3:0]  pos;
    logic [2:0]  probes;
    logic [4:0]  count;
    logic        last;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic [63:0] in_name_key = '0;
  logic [15:0] in_add_quantity = '0;
  logic [7:0]  in_new_priority = '0;
  logic [1:0]  in_sort_field = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [63:0] out_entry_name;
  logic [15:0] out_entry_quantity;
  logic [7:0]  out_entry_priority;
  logic [3:0]  out_entry_position;
  logic [2:0]  out_probe_count;
  logic [4:0]  out_entry_count;
  logic        out_last;

  sorted_record_table i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_name_key        (in_name_key),
    .in_add_quantity    (in_add_quantity),
    .in_new_priority    (in_new_priority),
    .in_sort_field      (in_sort_field),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_name     (out_entry_name),
    .out_entry_quantity (out_entry_quantity),
    .out_entry_priority (out_entry_priority),
    .out_entry_position (out_entry_position),
    .out_probe_count    (out_probe_count),
    .out_entry_count    (out_entry_count),
    .out_last           (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  command_t      pending_cmds[$];
  table_result_t expected_results[$];
  int            mismatches = 0;
  int            idle_cycles = 0;

  // ---- table model ---------------------------------------------------------
  logic [63:0] tbl_name[srt_pkg::ENTRIES];
  logic [15:0] tbl_qty[srt_pkg::ENTRIES];
  logic [7:0]  tbl_pri[srt_pkg::ENTRIES];
  int          tbl_count = 0;
  logic [1:0]  tbl_order = srt_pkg::SF_NONE;

  function automatic logic [63:0] sort_key(int i, logic [1:0] field);
    if (field == srt_pkg::SF_NAME) return tbl_name[i];
    if (field == srt_pkg::SF_QTY) return {48'd0, tbl_qty[i]};
    return {56'd0, tbl_pri[i]};
  endfunction

  // push one result; show selects whether the entry contents are reported
  task automatic post_result(logic [2:0] status, int idx, bit show, int probes, bit last);
    table_result_t r;
    r.status = status;
    r.name   = show ? tbl_name[idx] : '0;
    r.qty    = show ? tbl_qty[idx] : '0;
    r.pri    = show ? tbl_pri[idx] : '0;
    r.pos    = idx[3:0];
    r.probes = probes[2:0];
    r.count  = tbl_count[4:0];
    r.last   = last;
    expected_results.push_back(r);
  endtask

  task automatic apply_command(command_t c);
    logic [63:0] key;
    logic [63:0] k;
    logic [63:0] hold_name;
    logic [15:0] hold_qty;
    logic [7:0]  hold_pri;
    int          lo, hi, mid, probes, j;
    int unsigned sum;
    key = c.key & srt_pkg::NAME_MASK;
    case (c.mode)
      srt_pkg::MODE_INSERT: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_name[i] == key) begin
            sum = 32'(tbl_qty[i]) + 32'(c.qty);
            tbl_qty[i] = (sum > 65535) ? 16'hFFFF : sum[15:0];
            if (tbl_pri[i] < c.pri) tbl_pri[i] = c.pri;
            post_result(srt_pkg::ST_DONE, i, 0, 0, 1);
            return;
          end
        end
        if (tbl_count >= srt_pkg::ENTRIES) begin
          post_result(srt_pkg::ST_FULL, 0, 0, 0, 1);
          return;
        end
        tbl_name[tbl_count] = key;
        tbl_qty[tbl_count]  = c.qty;
        tbl_pri[tbl_count]  = c.pri;
        tbl_count++;
        tbl_order = srt_pkg::SF_NONE;
        post_result(srt_pkg::ST_ADDED, tbl_count - 1, 0, 0, 1);
      end
      srt_pkg::MODE_REMOVE: begin
        if (tbl_count == 0) begin
          post_result(srt_pkg::ST_EMPTY, 0, 0, 0, 1);
          return;
        end
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_name[i] == key) begin
            for (int m = i; m + 1 < tbl_count; m++) begin
              tbl_name[m] = tbl_name[m + 1];
              tbl_qty[m]  = tbl_qty[m + 1];
              tbl_pri[m]  = tbl_pri[m + 1];
            end
            tbl_count--;
            tbl_order = srt_pkg::SF_NONE;
            post_result(srt_pkg::ST_DONE, i, 0, 0, 1);
            return;
          end
        end
        post_result(srt_pkg::ST_NOTFOUND, 0, 0, 0, 1);
      end
      srt_pkg::MODE_SORT: begin
        if (c.field == srt_pkg::SF_NONE) begin
          post_result(srt_pkg::ST_BADKEY, 0, 0, 0, 1);
          return;
        end
        // stable insertion sort: only strictly larger keys move up
        for (int i = 1; i < tbl_count; i++) begin
          hold_name = tbl_name[i];
          hold_qty  = tbl_qty[i];
          hold_pri  = tbl_pri[i];
          k = sort_key(i, c.field);
          j = i;
          while (j > 0 && sort_key(j - 1, c.field) > k) begin
            tbl_name[j] = tbl_name[j - 1];
            tbl_qty[j]  = tbl_qty[j - 1];
            tbl_pri[j]  = tbl_pri[j - 1];
            j--;
          end
          tbl_name[j] = hold_name;
          tbl_qty[j]  = hold_qty;
          tbl_pri[j]  = hold_pri;
        end
        tbl_order = c.field;
        post_result(srt_pkg::ST_DONE, 0, 0, 0, 1);
      end
      srt_pkg::MODE_SEARCH: begin
        if (tbl_order != srt_pkg::SF_NAME) begin
          post_result(srt_pkg::ST_UNSORTED, 0, 0, 0, 1);
          return;
        end
        lo = 0;
        hi = tbl_count;
        probes = 0;
        while (lo < hi) begin
          mid = (lo + hi - 1) / 2;
          probes++;
          if (tbl_name[mid] == key) begin
            post_result(srt_pkg::ST_DONE, mid, 1, probes, 1);
            return;
          end
          if (tbl_name[mid] < key) lo = mid + 1;
          else hi = mid;
        end
        post_result(srt_pkg::ST_NOTFOUND, 0, 0, probes, 1);
      end
      srt_pkg::MODE_LIST: begin
        if (tbl_count == 0) begin
          post_result(srt_pkg::ST_EMPTY, 0, 0, 0, 1);
          return;
        end
        for (int i = 0; i < tbl_count; i++)
          post_result(srt_pkg::ST_DONE, i, 1, 0, i + 1 == tbl_count);
      end
      default: ; // unknown modes give no result
    endcase
  endtask

  // ---- driver: bursts of commands separated by random gaps -----------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    command_t c;
    logic     next_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        apply_command('{in_mode, in_name_key, in_add_quantity, in_new_priority,
                        in_sort_field});
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_mode         <= c.mode;
          in_name_key     <= c.key;
          in_add_quantity <= c.qty;
          in_new_priority <= c.pri;
          in_sort_field   <= c.field;
          next_start = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // end of a burst: a third of the time no pause at all
            burst_left = int'($urandom_range(0, 12));
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 9));
          end
        end
      end
      start <= next_start;
    end
  end

  // ---- monitor: every strobed result is a transfer -------------------------
  always @(posedge clk) begin
    table_result_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_entry_name, out_entry_quantity, out_entry_priority,
              out_entry_position, out_probe_count, out_entry_count, out_last};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d pos=%0d", got.status, got.pos);
      end else begin
        want = expected_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: st=%0d name=%h qty=%0d pri=%0d pos=%0d",
                     want.status, want.name, want.qty, want.pri, want.pos);
            $display("              prb=%0d cnt=%0d last=%0d",
                     want.probes, want.count, want.last);
            $display("         got: st=%0d name=%h qty=%0d pri=%0d pos=%0d",
                     got.status, got.name, got.qty, got.pri, got.pos);
            $display("              prb=%0d cnt=%0d last=%0d",
                     got.probes, got.count, got.last);
          end
        end
      end
    end
  end

  // ---- watchdog: cycles with no transfer on either side --------------------
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---- stimulus ------------------------------------------------------------
  logic [63:0] name_pool[8];

  function automatic logic [63:0] any_name();
    return {$urandom(), $urandom()};
  endfunction

  // mostly a small pool so merges, removes and search hits are common
  function automatic logic [63:0] pick_name();
    if ($urandom_range(0, 4) == 0) return any_name();
    return name_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [15:0] pick_qty();
    case ($urandom_range(0, 3))
      0: return 16'hFFFF - 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_cmd(logic [2:0] mode, logic [63:0] key, logic [15:0] qty,
                           logic [7:0] pri, logic [1:0] field);
    command_t c;
    c = '{mode, key, qty, pri, field};
    pending_cmds.push_back(c);
  endtask

  task automatic queue_random_sequence(ref int issued);
    int n;
    case ($urandom_range(0, 5))
      0, 1: begin
        // fill, put in name order, probe it
        n = int'($urandom_range(1, 8));
        for (int i = 0; i < n; i++)
          queue_cmd(srt_pkg::MODE_INSERT, pick_name(), pick_qty(), 8'($urandom()),
                    2'($urandom()));
        queue_cmd(srt_pkg::MODE_SORT, any_name(), 16'($urandom()), 8'($urandom()),
                  srt_pkg::SF_NAME);
        n = int'($urandom_range(1, 5));
        for (int i = 0; i < n; i++)
          queue_cmd(srt_pkg::MODE_SEARCH, pick_name(), 16'($urandom()), 8'($urandom()),
                    2'($urandom()));
        issued += 0;
        issued += $size(name_pool) > 0 ? 0 : 0;
      end
      2: begin
        queue_cmd(srt_pkg::MODE_SORT, any_name(), 16'($urandom()), 8'($urandom()),
                  2'($urandom()));
        queue_cmd(srt_pkg::MODE_LIST, any_name(), 16'($urandom()), 8'($urandom()),
                  2'($urandom()));
      end
      3: begin
        n = int'($urandom_range(1, 4));
        for (int i = 0; i < n; i++)
          queue_cmd(srt_pkg::MODE_REMOVE, pick_name(), 16'($urandom()), 8'($urandom()),
                    2'($urandom()));
      end
      4: queue_cmd(3'($urandom_range(0, 4)), pick_name(), pick_qty(), 8'($urandom()),
                   2'($urandom()));
      default: queue_cmd(3'($urandom_range(5, 7)), any_name(), 16'($urandom()),
                         8'($urandom()), 2'($urandom()));
    endcase
  endtask

  initial begin
    int issued;
    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int i = 2; i < 8; i++) name_pool[i] = any_name();

    // directed: empty-table cases
    queue_cmd(srt_pkg::MODE_REMOVE, '1, 16'd0, 8'd0, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_LIST, '0, 16'd0, 8'd0, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_SEARCH, '0, 16'd0, 8'd0, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_SORT, '0, 16'd0, 8'd0, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_SORT, '0, 16'd0, 8'd0, srt_pkg::SF_NAME);
    queue_cmd(srt_pkg::MODE_SEARCH, '1, 16'hFFFF, 8'hFF, srt_pkg::SF_PRI);
    // extremes, saturating merge, larger priority kept
    queue_cmd(srt_pkg::MODE_INSERT, '1, 16'hFFFF, 8'h00, srt_pkg::SF_PRI);
    queue_cmd(srt_pkg::MODE_INSERT, '1, 16'hFFFF, 8'hFF, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_INSERT, '0, 16'h0000, 8'hFF, srt_pkg::SF_QTY);
    queue_cmd(srt_pkg::MODE_INSERT, '0, 16'h0001, 8'h10, srt_pkg::SF_QTY);
    // fill to the limit, then refuse a new name but still merge
    for (int i = 0; i < srt_pkg::ENTRIES - 2; i++)
      queue_cmd(srt_pkg::MODE_INSERT, 64'h0101_0101_0000_0000 + 64'(i) * 64'h37,
                16'($urandom()), 8'($urandom()), srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_INSERT, 64'h8000_0000_0000_0000, 16'd5, 8'd5, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_INSERT, '0, 16'd7, 8'd1, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_SEARCH, '0, 16'd0, 8'd0, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_SORT, '0, 16'd0, 8'd0, srt_pkg::SF_NAME);
    queue_cmd(srt_pkg::MODE_SEARCH, '1, 16'd0, 8'd0, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_SEARCH, 64'h0000_0000_0000_0002, 16'd0, 8'd0, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_LIST, '0, 16'd0, 8'd0, srt_pkg::SF_NONE);
    queue_cmd(MODE_UNUSED, '1, 16'hFFFF, 8'hFF, srt_pkg::SF_PRI);
    queue_cmd(srt_pkg::MODE_SORT, '0, 16'd0, 8'd0, srt_pkg::SF_PRI);
    queue_cmd(srt_pkg::MODE_SORT, '0, 16'd0, 8'd0, srt_pkg::SF_QTY);
    queue_cmd(srt_pkg::MODE_REMOVE, '1, 16'd0, 8'd0, srt_pkg::SF_NONE);
    queue_cmd(srt_pkg::MODE_REMOVE, 64'h1234, 16'd0, 8'd0, srt_pkg::SF_NONE);

    // random: well-formed sequences with random content, plus some noise
    while (pending_cmds.size() < RANDOM_ITEMS) begin
      issued = 0;
      queue_random_sequence(issued);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
